### design/uhfc_pkg.sv
// Shared types and constants for the UDP header filter and counter.
// No dependencies; every design module imports this package.
`timescale 1ns / 1ps

package uhfc_pkg;

  // Default length of the link header ahead of the IPv4 header
  localparam int LINK_HEADER_BYTES_DEF = 14;
  // IPv4 header (20 bytes) plus UDP header (8 bytes)
  localparam int HEADERS_AFTER_LINK = 28;
  localparam logic [7:0] UDP_PROTOCOL = 8'd17;

  // Depth of the record queue between parser and counter
  localparam int QUEUE_DEPTH = 2;

  // Configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Register map, in word order
  typedef enum logic [2:0] {
    REG_SRC_ADDR,
    REG_SRC_ADDR_ON,
    REG_SRC_PORT,
    REG_SRC_PORT_ON,
    REG_DST_ADDR,
    REG_DST_ADDR_ON,
    REG_DST_PORT,
    REG_DST_PORT_ON
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic        src_addr_on;
    logic [15:0] src_port;
    logic        src_port_on;
    logic [31:0] dst_addr;
    logic        dst_addr_on;
    logic [15:0] dst_port;
    logic        dst_port_on;
  } filter_cfg_t;

  // Header fields of one matched frame
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
  } hdr_rec_t;

endpackage

### design/uhfc_frame_if.sv
// Frame byte channel: valid/ready handshake, one frame byte per word.
// No dependencies.
`timescale 1ns / 1ps

interface uhfc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

### design/uhfc_result_if.sv
// Result channel: valid/ready handshake, one matched-frame record per word.
// No dependencies.
`timescale 1ns / 1ps

interface uhfc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] ip_length;
  logic [15:0] udp_length;
  logic [15:0] matched_count;
  logic [15:0] length_sum;

  modport source (
    output valid, output source_address, output destination_address,
    output source_port, output destination_port, output ip_length,
    output udp_length, output matched_count, output length_sum,
    input ready
  );
  modport sink (
    input valid, input source_address, input destination_address,
    input source_port, input destination_port, input ip_length,
    input udp_length, input matched_count, input length_sum,
    output ready
  );
endinterface

### design/udp_header_filter_counter.sv
// Top level: configuration registers on an APB-style port, parser, record
// queue and counter stage. Depends on uhfc_pkg, the channel interfaces,
// uhfc_parse, uhfc_queue and uhfc_count.
`timescale 1ns / 1ps

// Counts UDP frames that pass optional address and port filters. Frame bytes
// enter on the frame channel at one byte per clock with no gaps required; the
// parser holds header fields from fixed offsets (link header of
// LINK_HEADER_BYTES, then IPv4 and UDP headers). On the last byte of a frame
// that is UDP, at least LINK_HEADER_BYTES + 28 bytes long and matches every
// enabled filter, a record goes into a two-entry queue; the counter stage
// adds it to the wrapping 16-bit packet count and length sum and presents it
// on the result channel from its output register. The frame channel
// stalls only while that queue is full, which takes a stalled result channel
// and two queued records. Filter registers sit at byte address 4*index and
// read back; change them only while no frame is in flight.
module udp_header_filter_counter #(
  parameter int LINK_HEADER_BYTES = uhfc_pkg::LINK_HEADER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  uhfc_frame_if.sink                      frame,
  uhfc_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uhfc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [uhfc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [uhfc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import uhfc_pkg::*;

  filter_cfg_t cfg;
  reg_idx_t    reg_idx;
  logic        cfg_wr;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  hdr_rec_t    wr_rec;
  hdr_rec_t    rd_rec;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  // Write filter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_ADDR:    cfg.src_addr    <= pwdata[31:0];
        REG_SRC_ADDR_ON: cfg.src_addr_on <= pwdata[0];
        REG_SRC_PORT:    cfg.src_port    <= pwdata[15:0];
        REG_SRC_PORT_ON: cfg.src_port_on <= pwdata[0];
        REG_DST_ADDR:    cfg.dst_addr    <= pwdata[31:0];
        REG_DST_ADDR_ON: cfg.dst_addr_on <= pwdata[0];
        REG_DST_PORT:    cfg.dst_port    <= pwdata[15:0];
        REG_DST_PORT_ON: cfg.dst_port_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back filter registers
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SRC_ADDR:    prdata = cfg.src_addr;
      REG_SRC_ADDR_ON: prdata = CFG_DATA_W'(cfg.src_addr_on);
      REG_SRC_PORT:    prdata = CFG_DATA_W'(cfg.src_port);
      REG_SRC_PORT_ON: prdata = CFG_DATA_W'(cfg.src_port_on);
      REG_DST_ADDR:    prdata = cfg.dst_addr;
      REG_DST_ADDR_ON: prdata = CFG_DATA_W'(cfg.dst_addr_on);
      REG_DST_PORT:    prdata = CFG_DATA_W'(cfg.dst_port);
      REG_DST_PORT_ON: prdata = CFG_DATA_W'(cfg.dst_port_on);
      default:         prdata = '0;
    endcase
  end

  uhfc_parse #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .frame  (frame),
    .q_full (q_full),
    .push   (push),
    .rec    (wr_rec)
  );

  uhfc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (q_full),
    .valid  (q_valid),
    .rd_rec (rd_rec),
    .pop    (pop)
  );

  uhfc_count u_count (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rec   (rd_rec),
    .pop     (pop),
    .result  (result)
  );

endmodule

### design/uhfc_parse.sv
// Front end: takes frame bytes, captures header fields at fixed offsets and
// classifies each frame at its last byte. Depends on uhfc_pkg, uhfc_frame_if.
`timescale 1ns / 1ps

module uhfc_parse #(
  parameter int LINK_HEADER_BYTES = uhfc_pkg::LINK_HEADER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uhfc_pkg::filter_cfg_t cfg,
  uhfc_frame_if.sink            frame,
  input  logic                  q_full,
  output logic                  push,
  output uhfc_pkg::hdr_rec_t    rec
);
  import uhfc_pkg::*;

  localparam int FRAME_MIN = LINK_HEADER_BYTES + HEADERS_AFTER_LINK;
  localparam int POS_W     = $clog2(FRAME_MIN + 1);
  localparam int REL_W     = $clog2(HEADERS_AFTER_LINK);
  localparam logic [POS_W-1:0] POS_LINK = POS_W'(LINK_HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_MIN  = POS_W'(FRAME_MIN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_MIN - 1);

  // Byte offsets from the start of the IPv4 header
  localparam int OFF_IP_LEN   = 2;
  localparam int OFF_PROTO    = 9;
  localparam int OFF_SRC_ADDR = 12;
  localparam int OFF_DST_ADDR = 16;
  localparam int OFF_SRC_PORT = 20;
  localparam int OFF_DST_PORT = 22;
  localparam int OFF_UDP_LEN  = 24;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] rel_full;
  logic [REL_W-1:0] rel;
  logic             in_hdr;
  logic             accept;
  logic             match;

  logic [7:0]  proto;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] ip_len;
  logic [15:0] udp_len;

  // Stall only when the record queue cannot take a result
  assign frame.ready = !q_full;
  assign accept      = frame.valid && frame.ready;

  assign in_hdr   = (pos >= POS_LINK) && (pos < POS_MIN);
  assign rel_full = pos - POS_LINK;
  assign rel      = rel_full[REL_W-1:0];

  // Advance the byte position, saturate past the headers, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (frame.frame_end) begin
        pos <= '0;
      end else if (pos != POS_MIN) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Shift header bytes into their fields
  always_ff @(posedge clk) begin
    if (rst) begin
      proto    <= '0;
      src_addr <= '0;
      dst_addr <= '0;
      src_port <= '0;
      dst_port <= '0;
      ip_len   <= '0;
      udp_len  <= '0;
    end else if (accept && in_hdr) begin
      case (rel) inside
        [OFF_IP_LEN:OFF_IP_LEN+1]:     ip_len   <= {ip_len[7:0], frame.frame_byte};
        OFF_PROTO:                     proto    <= frame.frame_byte;
        [OFF_SRC_ADDR:OFF_SRC_ADDR+3]: src_addr <= {src_addr[23:0], frame.frame_byte};
        [OFF_DST_ADDR:OFF_DST_ADDR+3]: dst_addr <= {dst_addr[23:0], frame.frame_byte};
        [OFF_SRC_PORT:OFF_SRC_PORT+1]: src_port <= {src_port[7:0], frame.frame_byte};
        [OFF_DST_PORT:OFF_DST_PORT+1]: dst_port <= {dst_port[7:0], frame.frame_byte};
        [OFF_UDP_LEN:OFF_UDP_LEN+1]:   udp_len  <= {udp_len[7:0], frame.frame_byte};
        default: ;
      endcase
    end
  end

  // Classify: a frame long enough to reach the last header byte has no
  // capture left on its final byte, so the held fields are complete
  assign match = (pos >= POS_LAST)
              && (proto == UDP_PROTOCOL)
              && (!cfg.src_addr_on || (src_addr == cfg.src_addr))
              && (!cfg.src_port_on || (src_port == cfg.src_port))
              && (!cfg.dst_addr_on || (dst_addr == cfg.dst_addr))
              && (!cfg.dst_port_on || (dst_port == cfg.dst_port));

  assign push = accept && frame.frame_end && match;

  assign rec.src_addr = src_addr;
  assign rec.dst_addr = dst_addr;
  assign rec.src_port = src_port;
  assign rec.dst_port = dst_port;
  assign rec.ip_len   = ip_len;
  assign rec.udp_len  = udp_len;

endmodule

### design/uhfc_queue.sv
// Short record queue between the parser and the counter stage.
// Depends on uhfc_pkg.
`timescale 1ns / 1ps

module uhfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  uhfc_pkg::hdr_rec_t wr_rec,
  output logic               full,
  output logic               valid,
  output uhfc_pkg::hdr_rec_t rd_rec,
  input  logic               pop
);
  import uhfc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  hdr_rec_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_FULL);
  assign valid  = (count != '0);
  assign rd_rec = entries[rd_ptr];

  // Write the incoming record
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/uhfc_count.sv
// Back end: pops matched records, updates the packet count and length sum,
// and holds the result word in an output register. Depends on uhfc_pkg,
// uhfc_result_if.
`timescale 1ns / 1ps

module uhfc_count (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  uhfc_pkg::hdr_rec_t q_rec,
  output logic               pop,
  uhfc_result_if.source      result
);
  import uhfc_pkg::*;

  logic        out_valid;
  logic [15:0] packet_total;
  logic [15:0] length_total;
  logic [15:0] packet_total_next;
  logic [15:0] length_total_next;
  hdr_rec_t    out_rec;

  // Take a record when the output register is empty or being emptied
  assign pop = q_valid && (!out_valid || result.ready);

  assign packet_total_next = packet_total + 16'd1;
  assign length_total_next = length_total + q_rec.ip_len;

  // Hold the running totals and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      packet_total <= '0;
      length_total <= '0;
    end else begin
      if (pop) begin
        out_valid    <= 1'b1;
        packet_total <= packet_total_next;
        length_total <= length_total_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the record into the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= q_rec;
    end
  end

  assign result.valid               = out_valid;
  assign result.source_address      = out_rec.src_addr;
  assign result.destination_address = out_rec.dst_addr;
  assign result.source_port         = out_rec.src_port;
  assign result.destination_port    = out_rec.dst_port;
  assign result.ip_length           = out_rec.ip_len;
  assign result.udp_length          = out_rec.udp_len;
  assign result.matched_count       = packet_total;
  assign result.length_sum          = length_total;

endmodule
